/* rtl/assert_macros.svh */
// assertion helpers for the rtl, included by value_noise_3d
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge of clock, switched off while reset is high
`define VN3_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// trigger in one cycle, consequence in the next
`define VN3_ASSERT_NEXT(label, trig, prop, msg) \
   `VN3_ASSERT(label, (trig) |=> (prop), msg)

`endif

/* rtl/vn3_pkg.sv */
package vn3_pkg;

   typedef logic [23:0] q24_type;

   typedef struct packed {
      logic [31:0] lo;
      logic [31:0] hi;
   } cell_pair_type;

   localparam logic [31:0] HASH_PX = 32'h8da6b343;
   localparam logic [31:0] HASH_PY = 32'hd8163841;
   localparam logic [31:0] HASH_PZ = 32'hcb1ab31f;
   localparam logic [31:0] HASH_M1 = 32'h7feb352d;
   localparam logic [31:0] HASH_M2 = 32'h846ca68b;

   // 3 * 2^24, the constant term of the easing polynomial
   localparam logic [25:0] EASE_K = 26'd50331648;

   // register stages from an accepted transaction to the result register
   localparam int PIPE_DEPTH = 11;

endpackage

/* rtl/value_noise_3d.sv */
// channel   direction  handshake              payload
// req       in         req_valid/req_ready    req_coord_x, req_coord_y, req_coord_z
// rsp       out        rsp_valid/rsp_ready    rsp_noise_value
//
// one transaction per cycle sustained while rsp is not stalled; a result is offered from the last stage
// 11 register stages, the first loaded at the accepting edge: floor (1), hash (4),
// three lerp levels (2 each); easing runs alongside the hash
// reset is synchronous, active high, and clears only the stage valid bits
// a stall on rsp freezes every stage together, so nothing is dropped or repeated
`include "assert_macros.svh"

module value_noise_3d #(
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_coord_x,
   input  logic [31:0] req_coord_y,
   input  logic [31:0] req_coord_z,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [23:0] rsp_noise_value
);

   localparam int Depth = vn3_pkg::PIPE_DEPTH;

   // whole pipeline moves while the result register is empty or being taken
   logic pipe_en;

   logic [Depth-1:0] valid_ff;

   vn3_pkg::cell_pair_type cell_x, cell_y, cell_z;
   vn3_pkg::q24_type       ux, uy, uz;

   // weights are ready after 3 stages; realign with the lerp levels
   vn3_pkg::q24_type [1:0] ux_dly_ff;
   vn3_pkg::q24_type [3:0] uy_dly_ff;
   vn3_pkg::q24_type [5:0] uz_dly_ff;

   vn3_pkg::q24_type [7:0] corners;
   vn3_pkg::q24_type [3:0] lerp_x;
   vn3_pkg::q24_type [1:0] lerp_y;
   vn3_pkg::q24_type [0:0] lerp_z;

   assign pipe_en   = !rsp_valid || rsp_ready;
   assign req_ready = pipe_en;
   assign rsp_valid = valid_ff[Depth-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (pipe_en) begin
         valid_ff <= {valid_ff[Depth-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         ux_dly_ff <= {ux_dly_ff[0], ux};
         uy_dly_ff <= {uy_dly_ff[2:0], uy};
         uz_dly_ff <= {uz_dly_ff[4:0], uz};
      end
   end

   // floor and easing per axis
   vn3_axis_split #(.FRAC_BITS(FRAC_BITS)) u_split_x (
      .clock(clock), .en(pipe_en), .coord(req_coord_x), .cells(cell_x), .weight(ux)
   );
   vn3_axis_split #(.FRAC_BITS(FRAC_BITS)) u_split_y (
      .clock(clock), .en(pipe_en), .coord(req_coord_y), .cells(cell_y), .weight(uy)
   );
   vn3_axis_split #(.FRAC_BITS(FRAC_BITS)) u_split_z (
      .clock(clock), .en(pipe_en), .coord(req_coord_z), .cells(cell_z), .weight(uz)
   );

   // eight corner values, corner index bit 0 is x, bit 1 y, bit 2 z
   vn3_hash u_hash (
      .clock(clock), .en(pipe_en),
      .cx(cell_x), .cy(cell_y), .cz(cell_z),
      .corners(corners)
   );

   // blend along x: x00, x10, x01, x11
   vn3_lerp #(.LANES(4)) u_lerp_x (
      .clock(clock), .en(pipe_en),
      .a({corners[6], corners[4], corners[2], corners[0]}),
      .b({corners[7], corners[5], corners[3], corners[1]}),
      .u(ux_dly_ff[1]),
      .r(lerp_x)
   );

   // blend along y: y0, y1
   vn3_lerp #(.LANES(2)) u_lerp_y (
      .clock(clock), .en(pipe_en),
      .a({lerp_x[2], lerp_x[0]}),
      .b({lerp_x[3], lerp_x[1]}),
      .u(uy_dly_ff[3]),
      .r(lerp_y)
   );

   // blend along z, last stage doubles as the result register
   vn3_lerp #(.LANES(1)) u_lerp_z (
      .clock(clock), .en(pipe_en),
      .a(lerp_y[0]),
      .b(lerp_y[1]),
      .u(uz_dly_ff[5]),
      .r(lerp_z)
   );

   assign rsp_noise_value = lerp_z[0];

   // an accepted transaction always occupies the first stage
   `VN3_ASSERT_NEXT(a_accept_enters, req_valid && req_ready, valid_ff[0], "accepted transaction lost")
   // a stalled pipeline keeps its occupancy
   `VN3_ASSERT_NEXT(a_stall_holds, !pipe_en, $stable(valid_ff), "stage valid bits moved in a stall")
   // a new result only comes from the stage before the result register
   `VN3_ASSERT(a_rsp_source, $rose(rsp_valid) |-> $past(valid_ff[Depth-2]), "result without source")

endmodule

/* rtl/vn3_axis_split.sv */
module vn3_axis_split #(
   parameter int FRAC_BITS = 16
) (
   input  logic                  clock,
   input  logic                  en,
   input  logic [31:0]           coord,
   output vn3_pkg::cell_pair_type cells,
   output vn3_pkg::q24_type      weight
);

   localparam int PadBits = 24 - FRAC_BITS;
   localparam logic [31:0] FracMask = (32'd1 << FRAC_BITS) - 32'd1;

   vn3_pkg::cell_pair_type cells_ff;
   vn3_pkg::q24_type       t_a_ff;
   vn3_pkg::q24_type       t_b_ff;
   vn3_pkg::q24_type       t2_ff;
   vn3_pkg::q24_type       u_ff;

   logic [31:0] cell_lo;
   logic [23:0] t_in;
   logic [47:0] sq_prod;
   logic [25:0] ease_k;
   logic [49:0] ease_prod;

   function automatic logic [25:0] EASE_K_SUB(input vn3_pkg::q24_type t);
      return vn3_pkg::EASE_K - {1'b0, t, 1'b0};
   endfunction

   // floor toward minus infinity is an arithmetic shift
   assign cell_lo   = 32'($signed(coord) >>> FRAC_BITS);
   assign t_in      = 24'(coord & FracMask) << PadBits;
   assign sq_prod   = 48'(t_a_ff) * 48'(t_a_ff);
   assign ease_k    = EASE_K_SUB(t_b_ff);
   assign ease_prod = 50'(t2_ff) * 50'(ease_k);

   always_ff @(posedge clock) begin
      if (en) begin
         cells_ff.lo <= cell_lo;
         cells_ff.hi <= cell_lo + 32'd1;
         t_a_ff      <= t_in;
         t2_ff       <= sq_prod[47:24];
         t_b_ff      <= t_a_ff;
         u_ff        <= ease_prod[47:24];
      end
   end

   assign cells  = cells_ff;
   assign weight = u_ff;

endmodule

/* rtl/vn3_hash.sv */
module vn3_hash (
   input  logic                           clock,
   input  logic                           en,
   input  vn3_pkg::cell_pair_type         cx,
   input  vn3_pkg::cell_pair_type         cy,
   input  vn3_pkg::cell_pair_type         cz,
   output vn3_pkg::q24_type [7:0]         corners
);

   logic [1:0][31:0] px_ff, py_ff, pz_ff;
   logic [7:0][31:0] m1_ff, m2_ff;
   vn3_pkg::q24_type [7:0] corner_ff;

   logic [7:0][31:0] m1_in, m2_in;
   vn3_pkg::q24_type [7:0] corner_in;

   // corner c takes the high cell on x for bit 0, y for bit 1, z for bit 2
   always_comb begin
      logic [31:0] h;
      for (int c = 0; c < 8; c++) begin
         h = px_ff[c % 2] ^ py_ff[(c / 2) % 2] ^ pz_ff[c / 4];
         h = h ^ (h >> 16);
         m1_in[c] = h * vn3_pkg::HASH_M1;
         h = m1_ff[c] ^ (m1_ff[c] >> 15);
         m2_in[c] = h * vn3_pkg::HASH_M2;
         h = m2_ff[c] ^ (m2_ff[c] >> 16);
         corner_in[c] = h[31:8];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff[0]  <= cx.lo * vn3_pkg::HASH_PX;
         px_ff[1]  <= cx.hi * vn3_pkg::HASH_PX;
         py_ff[0]  <= cy.lo * vn3_pkg::HASH_PY;
         py_ff[1]  <= cy.hi * vn3_pkg::HASH_PY;
         pz_ff[0]  <= cz.lo * vn3_pkg::HASH_PZ;
         pz_ff[1]  <= cz.hi * vn3_pkg::HASH_PZ;
         m1_ff     <= m1_in;
         m2_ff     <= m2_in;
         corner_ff <= corner_in;
      end
   end

   assign corners = corner_ff;

endmodule

/* rtl/vn3_lerp.sv */
module vn3_lerp #(
   parameter int LANES = 4
) (
   input  logic                         clock,
   input  logic                         en,
   input  vn3_pkg::q24_type [LANES-1:0] a,
   input  vn3_pkg::q24_type [LANES-1:0] b,
   input  vn3_pkg::q24_type             u,
   output vn3_pkg::q24_type [LANES-1:0] r
);

   // a + floor((b - a) * u / 2^24), same as the two-product form
   vn3_pkg::q24_type [LANES-1:0]        base_ff;
   logic signed [LANES-1:0][49:0]       prod_ff;
   vn3_pkg::q24_type [LANES-1:0]        r_ff;

   logic signed [LANES-1:0][49:0]       prod_in;
   vn3_pkg::q24_type [LANES-1:0]        r_in;

   always_comb begin
      logic signed [24:0] diff;
      logic signed [24:0] uval;
      logic [25:0]        sum;
      for (int l = 0; l < LANES; l++) begin
         diff       = $signed({1'b0, b[l]}) - $signed({1'b0, a[l]});
         uval       = $signed({1'b0, u});
         prod_in[l] = 50'(diff * uval);
         sum        = {2'b00, base_ff[l]} + prod_ff[l][49:24];
         r_in[l]    = sum[23:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         base_ff <= a;
         prod_ff <= prod_in;
         r_ff    <= r_in;
      end
   end

   assign r = r_ff;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;

   localparam int FRAC_BITS = 16;

   // hash primes and mixing multipliers of the lattice hash
   localparam logic [31:0] PRIME_X = 32'h8da6b343;
   localparam logic [31:0] PRIME_Y = 32'hd8163841;
   localparam logic [31:0] PRIME_Z = 32'hcb1ab31f;
   localparam logic [31:0] MIX_A   = 32'h7feb352d;
   localparam logic [31:0] MIX_B   = 32'h846ca68b;

   localparam logic [63:0] Q24_UNIT = 64'd16777216;

   localparam int RANDOM_POINTS = 1200;
   localparam int DRAIN_CYCLES  = 40;       // well past the pipeline depth
   localparam int CYCLE_LIMIT   = 200000;
   localparam int IDLE_PERCENT  = 18;
   localparam int HOLD_CYCLES   = 250;      // long rsp stall to back up the pipe

   // one row of stimulus: three coordinates, and a hand-worked answer where known
   typedef struct packed {
      logic [31:0] coord_x;
      logic [31:0] coord_y;
      logic [31:0] coord_z;
      logic        known;
      logic [23:0] noise;
   } lattice_point_type;

   localparam int TABLE_ROWS = 20;

   // only the origin has an answer obvious by hand: every hash of zero is zero
   lattice_point_type point_table [0:TABLE_ROWS-1] = '{
      {32'h00000000, 32'h00000000, 32'h00000000, 1'b1, 24'h000000},
      // largest coordinate on every axis
      {32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0, 24'h0},
      // most negative, integral
      {32'h80000000, 32'h80000000, 32'h80000000, 1'b0, 24'h0},
      // just below zero: cell -1, the upper corner wraps round to cell 0
      {32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b0, 24'h0},
      // integral coordinates give the lower corner value
      {32'h00010000, 32'h00020000, 32'h00030000, 1'b0, 24'h0},
      {32'hffff0000, 32'hffff0000, 32'hffff0000, 1'b0, 24'h0},
      // half-way, and the fraction at its extremes
      {32'h00008000, 32'h00008000, 32'h00008000, 1'b0, 24'h0},
      {32'h0000ffff, 32'h0000ffff, 32'h0000ffff, 1'b0, 24'h0},
      {32'h00000001, 32'h00000001, 32'h00000001, 1'b0, 24'h0},
      // mixed extremes across the axes
      {32'h7fff0000, 32'h80000000, 32'h00000000, 1'b0, 24'h0},
      {32'h7fffffff, 32'h00000000, 32'h80000000, 1'b0, 24'h0},
      {32'h12345678, 32'h9abcdef0, 32'h0f1e2d3c, 1'b0, 24'h0},
      {32'hffff8000, 32'h00018000, 32'h7fff8000, 1'b0, 24'h0},
      {32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 1'b0, 24'h0},
      {32'h55555555, 32'haaaaaaaa, 32'h55555555, 1'b0, 24'h0},
      {32'h00004000, 32'h0000c000, 32'h00002000, 1'b0, 24'h0},
      // one axis at a time carrying a fraction, then a row with a fraction on all three
      {32'hdeadbeef, 32'h00000000, 32'h00000000, 1'b0, 24'h0},
      {32'h00000000, 32'hdeadbeef, 32'h00000000, 1'b0, 24'h0},
      {32'h00000000, 32'h00000000, 32'hdeadbeef, 1'b0, 24'h0},
      {32'h80000001, 32'h7fff0001, 32'hfffffffe, 1'b0, 24'h0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_coord_x = '0;
   logic [31:0] req_coord_y = '0;
   logic [31:0] req_coord_z = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [23:0] rsp_noise_value;

   lattice_point_type point_queue [$];
   logic [23:0]       pending_noise [$];    // expected results, oldest first
   logic [23:0]       offered_noise = '0;   // expectation for the transaction on req
   logic [23:0]       oldest_noise;
   lattice_point_type next_point;
   int                points_total;
   int                points_accepted = 0;
   int                results_seen = 0;
   int                mismatch_count = 0;
   int                cycle_count = 0;
   int                hold_left = 0;
   bit                hold_done = 1'b0;

   value_noise_3d #(
      .FRAC_BITS(FRAC_BITS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_coord_x    (req_coord_x),
      .req_coord_y    (req_coord_y),
      .req_coord_z    (req_coord_z),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_noise_value(rsp_noise_value)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------

   // three-prime multiply-xor hash, all products wrap at 32 bits
   function automatic logic [23:0] lattice_hash(input logic [31:0] cx,
                                                input logic [31:0] cy,
                                                input logic [31:0] cz);
      logic [31:0] h;
      h = cx * PRIME_X;
      h ^= cy * PRIME_Y;
      h ^= cz * PRIME_Z;
      h ^= h >> 16;
      h = h * MIX_A;
      h ^= h >> 15;
      h = h * MIX_B;
      h ^= h >> 16;
      return h[31:8];
   endfunction

   // floored cell index and smoothstep-eased Q0.24 weight of one coordinate
   function automatic void split_coord(input logic [31:0] coord,
                                       output logic [31:0] cell_idx,
                                       output logic [63:0] weight);
      logic [63:0] frac;
      logic [63:0] frac_sq;
      cell_idx = $signed(coord) >>> FRAC_BITS;
      frac     = 64'(coord & ((32'd1 << FRAC_BITS) - 32'd1)) << (24 - FRAC_BITS);
      frac_sq  = (frac * frac) >> 24;
      weight   = (frac_sq * (3 * Q24_UNIT - 2 * frac)) >> 24;
   endfunction

   // truncating linear blend, result always lies between a and b
   function automatic logic [63:0] blend(input logic [63:0] a,
                                         input logic [63:0] b,
                                         input logic [63:0] w);
      return (a * (Q24_UNIT - w) + b * w) >> 24;
   endfunction

   function automatic logic [23:0] expected_noise(input logic [31:0] x,
                                                  input logic [31:0] y,
                                                  input logic [31:0] z);
      logic [31:0] ix, iy, iz, jx, jy, jz;
      logic [63:0] ux, uy, uz;
      logic [63:0] e00, e10, e01, e11, f0, f1, g;
      split_coord(x, ix, ux);
      split_coord(y, iy, uy);
      split_coord(z, iz, uz);
      // upper corners wrap modulo 2^32
      jx = ix + 32'd1;
      jy = iy + 32'd1;
      jz = iz + 32'd1;
      // along x first, then y, then z
      e00 = blend(lattice_hash(ix, iy, iz), lattice_hash(jx, iy, iz), ux);
      e10 = blend(lattice_hash(ix, jy, iz), lattice_hash(jx, jy, iz), ux);
      e01 = blend(lattice_hash(ix, iy, jz), lattice_hash(jx, iy, jz), ux);
      e11 = blend(lattice_hash(ix, jy, jz), lattice_hash(jx, jy, jz), ux);
      f0  = blend(e00, e10, uy);
      f1  = blend(e01, e11, uy);
      g   = blend(f0, f1, uz);
      return g[23:0];
   endfunction

   // ---------------------------------------------------------------------------
   // random coordinates, biased towards the interesting corners of the format
   // ---------------------------------------------------------------------------
   function automatic logic [31:0] random_coord();
      logic [31:0] c;
      c = $urandom;
      case ($urandom_range(0, 9))
         6: begin
            // integral: weight is zero, lower corner only
            c[15:0] = 16'h0000;
         end
         7: begin
            // close to the origin, either sign
            c = $urandom_range(0, 32'h0007ffff) - 32'h00040000;
         end
         8: begin
            // fraction at its extremes, random cell
            case ($urandom_range(0, 4))
               0: c[15:0] = 16'h0000;
               1: c[15:0] = 16'h0001;
               2: c[15:0] = 16'h8000;
               3: c[15:0] = 16'hfffe;
               default: c[15:0] = 16'hffff;
            endcase
         end
         9: begin
            // cell at its extremes, random fraction
            case ($urandom_range(0, 3))
               0: c[31:16] = 16'h7fff;
               1: c[31:16] = 16'h8000;
               2: c[31:16] = 16'hffff;
               default: c[31:16] = 16'h0000;
            endcase
         end
         default: begin
         end
      endcase
      return c;
   endfunction

   // ---------------------------------------------------------------------------
   // request side: offers transactions from the queue, with random idle cycles
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            pending_noise.push_back(offered_noise);
            points_accepted++;
         end
         // a new point may go out once the current one has been taken
         if (!req_valid || req_ready) begin
            if (point_queue.size() != 0 &&
                ((points_accepted >= 300 && points_accepted < 500) ||
                 $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               next_point = point_queue.pop_front();
               req_valid     <= 1'b1;
               req_coord_x   <= next_point.coord_x;
               req_coord_y   <= next_point.coord_y;
               req_coord_z   <= next_point.coord_z;
               offered_noise <= next_point.known ? next_point.noise :
                                expected_noise(next_point.coord_x,
                                               next_point.coord_y,
                                               next_point.coord_z);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // response side: checks each transaction against the oldest expectation
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_noise.size() == 0) begin
               $error("noise_value: no result expected, actual %h", rsp_noise_value);
               mismatch_count++;
            end else begin
               oldest_noise = pending_noise.pop_front();
               if (rsp_noise_value !== oldest_noise) begin
                  $error("noise_value: expected %h, actual %h",
                         oldest_noise, rsp_noise_value);
                  mismatch_count++;
               end
            end
            results_seen++;
         end
         // one long hold-off partway through so that the pipe fills and req stalls
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!hold_done && results_seen >= 400) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= (results_seen >= 700 && results_seen < 900) ||
                         ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // sequence: fill the queue, release reset, wait for everything to drain
   // ---------------------------------------------------------------------------
   initial begin
      for (int i = 0; i < TABLE_ROWS; i++) begin
         point_queue.push_back(point_table[i]);
      end
      for (int i = 0; i < RANDOM_POINTS; i++) begin
         next_point.coord_x = random_coord();
         next_point.coord_y = random_coord();
         next_point.coord_z = random_coord();
         next_point.known   = 1'b0;
         next_point.noise   = '0;
         point_queue.push_back(next_point);
      end
      points_total = point_queue.size();

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (points_accepted < points_total || pending_noise.size() != 0) begin
         @(posedge clock);
      end
      // catch any stray result the block might still push out
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
